[sv/bit_stuffing_framer_top_macros.svh]
// Assertion macros for the bit stuffing framer.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BIT_STUFFING_FRAMER_TOP_MACROS_SVH
`define BIT_STUFFING_FRAMER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define BSF_ASSERT_IMPLY(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define BSF_ASSERT_NEXT(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[sv/bsf_pkg.sv]
package bsf_pkg;

    localparam int BSF_STUFF_RUN   = 5;
    localparam int BSF_MAX_RESULTS = 26;
    localparam int BSF_CNT_W       = $clog2(BSF_MAX_RESULTS);
    localparam int BSF_ONES_W      = 3;
    localparam int BSF_QUEUE_DEPTH = 2;
    localparam logic [7:0] BSF_FLAG_RESET = 8'h7E;

    // One classified item as it waits for the serializer
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
        logic       open_frame;
        logic [7:0] flag;
    } bsf_job_t;

    // Front to queue write request
    typedef struct packed {
        logic     valid;
        bsf_job_t job;
    } bsf_push_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic valid;
        logic full;
    } bsf_qstat_t;

endpackage

[sv/bsf_intf.sv]
interface bsf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface bsf_out_if;
    logic valid;
    logic ready;
    logic line_bit;
    logic end_of_run;
    logic end_of_frame;

    modport source (output valid, output line_bit, output end_of_run,
                    output end_of_frame, input ready);
    modport sink   (input valid, input line_bit, input end_of_run,
                    input end_of_frame, output ready);
endinterface

interface bsf_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] flag_pattern;

    modport source (output valid, output flag_pattern, input ready);
    modport sink   (input valid, input flag_pattern, output ready);
endinterface

[sv/bsf_front.sv]
module bsf_front
    import bsf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bsf_in_if.sink       frame_in,
    bsf_cfg_if.sink      cfg,
    input  bsf_qstat_t   qstat,
    output bsf_push_t    push
);

    logic [7:0] flag_reg;
    logic       inside_reg;
    logic       accept;

    // Take a new item whenever the queue has room
    assign frame_in.ready = !qstat.full;
    assign cfg.ready      = 1'b1;
    assign accept         = frame_in.valid && !qstat.full;

    // Classify: open a frame when none is open, capture the flag in use
    assign push.valid           = accept;
    assign push.job.byte_value  = frame_in.byte_value;
    assign push.job.last_byte   = frame_in.last_byte;
    assign push.job.open_frame  = !inside_reg;
    assign push.job.flag        = flag_reg;

    // Hold the flag register and the frame-open mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg   <= BSF_FLAG_RESET;
            inside_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                flag_reg <= cfg.flag_pattern;
            end
            if (accept)
            begin
                inside_reg <= !frame_in.last_byte;
            end
        end
    end

endmodule

[sv/bsf_queue.sv]
module bsf_queue
    import bsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bsf_push_t   push,
    input  logic        pop,
    output bsf_job_t    head,
    output bsf_qstat_t  qstat
);

    localparam int PTR_W = (BSF_QUEUE_DEPTH > 1) ? $clog2(BSF_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(BSF_QUEUE_DEPTH + 1);

    bsf_job_t           mem_reg [BSF_QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign qstat.valid = (count_reg != '0);
    assign qstat.full  = (count_reg == CNT_W'(BSF_QUEUE_DEPTH));
    assign head        = mem_reg[rd_ptr_reg];
    assign do_push     = push.valid && !qstat.full;
    assign do_pop      = pop && qstat.valid;

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(BSF_QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(BSF_QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

[sv/bsf_back.sv]
module bsf_back
    import bsf_pkg::*;
#(
    parameter int STUFF_RUN = BSF_STUFF_RUN
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  bsf_job_t    head,
    input  bsf_qstat_t  qstat,
    output logic        pop,
    bsf_out_if.source   line_out
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_OPEN  = 5'b00010,
        ST_DATA  = 5'b00100,
        ST_STUFF = 5'b01000,
        ST_CLOSE = 5'b10000
    } bsf_state_t;

    bsf_state_t             state_reg;
    bsf_state_t             state_next;
    bsf_job_t               job_reg;
    bsf_job_t               job_next;
    logic [2:0]             idx_reg;
    logic [2:0]             idx_next;
    logic                   done_reg;
    logic                   done_next;
    logic [BSF_ONES_W-1:0]  ones_reg;
    logic [BSF_ONES_W-1:0]  ones_next;
    logic [BSF_ONES_W-1:0]  ones_inc;
    logic [BSF_CNT_W-1:0]   count_reg;
    logic [BSF_CNT_W-1:0]   count_next;
    logic                   out_valid_reg;
    logic                   out_bit_reg;
    logic                   out_eor_reg;
    logic                   out_eof_reg;
    logic                   out_free;
    logic                   emit;
    logic                   cur_bit;
    logic                   natural_end;
    logic                   fin;
    logic                   stuff;

    assign line_out.valid        = out_valid_reg;
    assign line_out.line_bit     = out_bit_reg;
    assign line_out.end_of_run   = out_eor_reg;
    assign line_out.end_of_frame = out_eof_reg;

    assign out_free = !out_valid_reg || line_out.ready;
    assign emit     = (state_reg != ST_IDLE) && out_free;
    assign ones_inc = cur_bit ? ones_reg + 1'b1 : '0;
    assign stuff    = (state_reg == ST_DATA) && (ones_inc == BSF_ONES_W'(STUFF_RUN));
    // End the item at its natural end, or cut it off at the result limit
    assign fin      = natural_end || (count_reg == BSF_CNT_W'(BSF_MAX_RESULTS - 1));

    // Select the bit on the line
    always_comb
    begin
        cur_bit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cur_bit = 1'b0;
            end
            ST_OPEN:
            begin
                cur_bit = job_reg.flag[idx_reg];
            end
            ST_DATA:
            begin
                cur_bit = job_reg.byte_value[idx_reg];
            end
            ST_STUFF:
            begin
                cur_bit = 1'b0;
            end
            ST_CLOSE:
            begin
                cur_bit = job_reg.flag[idx_reg];
            end
            default:
            begin
                cur_bit = 1'b0;
            end
        endcase
    end

    // Spot the natural end of the item
    always_comb
    begin
        natural_end = 1'b0;
        unique case (state_reg)
            ST_DATA:
            begin
                natural_end = !stuff && (idx_reg == 3'd7) && !job_reg.last_byte;
            end
            ST_STUFF:
            begin
                natural_end = done_reg && !job_reg.last_byte;
            end
            ST_CLOSE:
            begin
                natural_end = (idx_reg == 3'd7);
            end
            default:
            begin
                natural_end = 1'b0;
            end
        endcase
    end

    // Sequence flag, data, stuffing and closing flag bits
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        done_next  = done_reg;
        ones_next  = ones_reg;
        count_next = count_reg;
        pop        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (qstat.valid)
                begin
                    pop        = 1'b1;
                    job_next   = head;
                    state_next = head.open_frame ? ST_OPEN : ST_DATA;
                    idx_next   = '0;
                    done_next  = 1'b0;
                    count_next = '0;
                    if (head.open_frame)
                    begin
                        ones_next = '0;
                    end
                end
            end
            ST_OPEN:
            begin
                if (emit)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (emit)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (stuff)
                    begin
                        ones_next  = '0;
                        done_next  = (idx_reg == 3'd7);
                        state_next = ST_STUFF;
                    end
                    else
                    begin
                        ones_next = ones_inc;
                        if (idx_reg == 3'd7)
                        begin
                            state_next = ST_CLOSE;
                        end
                    end
                end
            end
            ST_STUFF:
            begin
                if (emit)
                begin
                    ones_next  = '0;
                    state_next = done_reg ? ST_CLOSE : ST_DATA;
                end
            end
            ST_CLOSE:
            begin
                if (emit)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            count_next = count_reg + 1'b1;
            if (fin)
            begin
                state_next = ST_IDLE;
                if (job_reg.last_byte)
                begin
                    ones_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ones_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ones_reg  <= ones_next;
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    // Payload and sequencing registers
    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        idx_reg   <= idx_next;
        done_reg  <= done_next;
        count_reg <= count_next;
        if (emit)
        begin
            out_bit_reg <= cur_bit;
            out_eor_reg <= fin;
            out_eof_reg <= fin && job_reg.last_byte;
        end
    end

endmodule

[sv/bit_stuffing_framer_top.sv]
// Bit stuffing framer: bytes in, a stuffed serial bit stream out.
// frame_in carries one byte per item with last_byte set on the final byte
// of a frame; line_out carries one line bit per item with end_of_run on the
// last bit caused by an input byte and end_of_frame on the last bit of the
// closing flag. cfg writes the flag pattern; write it only while idle.
// The first input byte of a frame is preceded by the flag, a byte marked
// last is followed by it; a zero is inserted after STUFF_RUN data ones.
// The first bit of an item passes through the queue, the job register and
// the output register before it is valid. The serializer loads one item at
// a time in idle and sends its flag, data and stuffing bits at one bit per
// cycle unless the receiver stalls; the next item waits in the queue.
// A two-entry queue decouples the input from the serializer, so up to two
// bytes are taken ahead while bits drain.
// Reset loads the flag 0x7E, closes any open frame and empties the queue.
// When the receiver stalls, the output bit holds and the serializer waits;
// the input side stops once the queue is full.
`include "bit_stuffing_framer_top_macros.svh"

module bit_stuffing_framer_top
    import bsf_pkg::*;
#(
    parameter int STUFF_RUN = BSF_STUFF_RUN
)
(
    input  logic        clk,
    input  logic        rst_n,
    bsf_in_if.sink      frame_in,
    bsf_cfg_if.sink     cfg,
    bsf_out_if.source   line_out
);

    bsf_push_t   push;
    bsf_qstat_t  qstat;
    bsf_job_t    head;
    logic        pop;

    // Accept and classify items
    bsf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame_in (frame_in),
        .cfg      (cfg),
        .qstat    (qstat),
        .push     (push)
    );

    // Buffer classified items
    bsf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    // Serialize with flags and stuffing
    bsf_back #(
        .STUFF_RUN (STUFF_RUN)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .qstat    (qstat),
        .pop      (pop),
        .line_out (line_out)
    );

    `BSF_ASSERT_IMPLY(a_pop_nonempty, pop, qstat.valid, "pop from empty queue")
    `BSF_ASSERT_IMPLY(a_eof_ends_run, line_out.valid && line_out.end_of_frame, line_out.end_of_run, "eof without eor")
    `BSF_ASSERT_NEXT(a_full_blocks_input, qstat.full && !pop, !frame_in.ready, "input ready while queue full")

endmodule
